// ===== sv/rqss_pkg.sv =====
// ----------------------------------------------------------------------------
// rqss_pkg
// Shared types for the SJF/SRTF ready queue: request and result items,
// queue entry layout, and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package rqss_pkg;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_FRONT  = 2'd2,
        REQ_LEAST  = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        req_code_t   req_type;
        logic [7:0]  thread_id;
        logic [15:0] burst_len;
        logic [15:0] remain_len;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  out_id;
        logic [15:0] out_burst;
        logic [15:0] out_remain;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] burst;
        logic [15:0] remain;
    } entry_t;

    typedef struct packed {
        logic load;        // latch request, set up the scan
        logic scan;        // walk entries for position / minimum
        logic shift_init;  // set up the move pass from the found position
        logic shift;       // move entries by one place
        logic commit;      // write result, place entry, update count
    } dp_cmd_t;

    typedef struct packed {
        logic bad;         // full on insert or empty on take
        logic move_done;   // walk finished, no read in flight
        logic out_free;    // result register can take a new item
    } dp_sts_t;

endpackage

// ===== sv/rqss_ctrl.sv =====
// ----------------------------------------------------------------------------
// rqss_ctrl
// Request sequencer: load, scan, move, respond.
// ----------------------------------------------------------------------------
module rqss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rqss_pkg::dp_sts_t sts,
    output rqss_pkg::dp_cmd_t cmd
);
    import rqss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    always_comb
    begin
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    state_next    = S_SCAN;
                    in_ready_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                cmd.scan = !sts.bad;
                if (sts.bad)
                begin
                    state_next = S_DONE;
                end
                else if (sts.move_done)
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.move_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit    = 1'b1;
                    state_next    = S_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// ===== sv/rqss_dp.sv =====
// ----------------------------------------------------------------------------
// rqss_dp
// Queue datapath: entry memory, walk engine, result register.
// ----------------------------------------------------------------------------
module rqss_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rqss_pkg::req_t    in_item,
    input  rqss_pkg::dp_cmd_t cmd,
    output rqss_pkg::dp_sts_t sts,
    output logic              out_valid,
    input  logic              out_ready,
    output rqss_pkg::rsp_t    out_item
);
    import rqss_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    entry_t mem [QUEUE_DEPTH];

    req_t          item_reg,   item_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [CW-1:0] pos_reg,    pos_next;
    logic [CW-1:0] idx_reg,    idx_next;
    logic [CW-1:0] left_reg,   left_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_vld_reg, rd_vld_next;
    logic          found_reg,  found_next;
    entry_t        best_reg,   best_next;
    entry_t        rd_data_reg;
    rsp_t          res_reg,    res_next;
    logic          res_vld_reg, res_vld_next;

    logic          is_ins;
    logic          bad;
    logic          rd_en;
    logic          step_down;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    entry_t        wr_data;
    entry_t        new_e;
    logic [CW-1:0] lim;

    assign is_ins = (item_reg.req_type == REQ_APPEND) || (item_reg.req_type == REQ_INSERT);
    assign bad    = is_ins ? (count_reg == DEPTH_C) : (count_reg == '0);
    assign rd_en  = (cmd.scan || cmd.shift) && (left_reg != '0);
    assign step_down = cmd.shift && is_ins;

    assign new_e.id     = item_reg.thread_id;
    assign new_e.burst  = item_reg.burst_len;
    assign new_e.remain = item_reg.remain_len;

    // reads needed by the scan for each request
    always_comb
    begin
        unique case (in_item.req_type)
            REQ_APPEND: lim = '0;
            REQ_INSERT: lim = count_reg;
            REQ_FRONT:  lim = (count_reg != '0) ? ONE_C : '0;
            REQ_LEAST:  lim = count_reg;
            default:    lim = '0;
        endcase
    end

    // write port: moved entry during shift, new entry at commit
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = new_e;
        if (cmd.shift && rd_vld_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = is_ins ? (rd_idx_reg + ONE_C) : (rd_idx_reg - ONE_C);
            wr_data = rd_data_reg;
        end
        else if (cmd.commit && !bad && is_ins)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        item_next    = item_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        left_next    = left_reg;
        rd_idx_next  = idx_reg;
        rd_vld_next  = rd_en;
        found_next   = found_reg;
        best_next    = best_reg;
        res_next     = res_reg;
        res_vld_next = res_vld_reg && !out_ready;

        if (rd_en)
        begin
            idx_next  = step_down ? (idx_reg - ONE_C) : (idx_reg + ONE_C);
            left_next = left_reg - ONE_C;
        end

        if (cmd.load)
        begin
            item_next  = in_item;
            idx_next   = '0;
            left_next  = lim;
            found_next = 1'b0;
            pos_next   = ((in_item.req_type == REQ_APPEND) ||
                          (in_item.req_type == REQ_INSERT)) ? count_reg : '0;
        end

        if (cmd.scan && rd_vld_reg)
        begin
            if (is_ins)
            begin
                if ((item_reg.req_type == REQ_INSERT) && !found_reg &&
                    (rd_data_reg.burst > item_reg.burst_len))
                begin
                    found_next = 1'b1;
                    pos_next   = rd_idx_reg;
                end
            end
            else if ((rd_idx_reg == '0) || (rd_data_reg.remain < best_reg.remain))
            begin
                best_next = rd_data_reg;
                pos_next  = rd_idx_reg;
            end
        end

        if (cmd.shift_init)
        begin
            if (is_ins)
            begin
                idx_next  = count_reg - ONE_C;
                left_next = count_reg - pos_reg;
            end
            else
            begin
                idx_next  = pos_reg + ONE_C;
                left_next = count_reg - ONE_C - pos_reg;
            end
        end

        if (cmd.commit)
        begin
            res_vld_next = 1'b1;
            res_next     = '0;
            if (bad)
            begin
                res_next.status = is_ins ? ST_FULL : ST_EMPTY;
            end
            else if (is_ins)
            begin
                res_next.status = ST_OK;
                count_next      = count_reg + ONE_C;
            end
            else
            begin
                res_next.status     = ST_OK;
                res_next.out_id     = best_reg.id;
                res_next.out_burst  = best_reg.burst;
                res_next.out_remain = best_reg.remain;
                count_next          = count_reg - ONE_C;
            end
        end
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        rd_data_reg <= mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            left_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            left_reg    <= left_next;
            rd_vld_reg  <= rd_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        rd_idx_reg <= rd_idx_next;
        found_reg  <= found_next;
        best_reg   <= best_next;
        res_reg    <= res_next;
    end

    assign sts.bad       = bad;
    assign sts.move_done = (left_reg == '0) && !rd_vld_reg;
    assign sts.out_free  = !res_vld_reg || out_ready;

    assign out_valid = res_vld_reg;
    assign out_item  = res_reg;

endmodule

// ===== sv/ready_queue_fifo_sjf_srtf_top.sv =====
// ----------------------------------------------------------------------------
// ready_queue_fifo_sjf_srtf_top
// Ordered ready queue of thread entries with FIFO, burst-ordered insert,
// take-front and take-least-remaining requests.
// ----------------------------------------------------------------------------
//
//  channel | signals                         | payload
//  --------+---------------------------------+-----------------------------
//  request | in_valid / in_ready / in_item   | req_type, thread_id,
//          |                                 | burst_len, remain_len
//  result  | out_valid / out_ready / out_item| status, out_id, out_burst,
//          |                                 | out_remain
//
//  One request in flight at a time; every request gives exactly one result.
//  Time per item is set by the single read port of the entry memory:
//  one pass to find the position or minimum, one pass to move entries
//  by one place. Full insert and empty take skip both passes.
//  Reset clears the entry count; no clearing pass over the memory.
//  A stalled result sits in the output register; the next request is held
//  only when its own result is ready and the previous one is not yet taken.
//
module ready_queue_fifo_sjf_srtf_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rqss_pkg::req_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output rqss_pkg::rsp_t out_item
);
    import rqss_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer: load -> scan -> move -> respond
    rqss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // entry memory, walk engine and result register
    rqss_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

`ifndef NO_ASSERTIONS
    // only one request at a time: accepting one closes the input
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in progress");

    // full and empty answers carry no entry
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.status != ST_OK)) |->
        ((out_item.out_id == '0) && (out_item.out_burst == '0) &&
         (out_item.out_remain == '0)))
        else $error("error result carries entry data");

    // a result never appears in the cycle right after a request is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> !out_valid)
        else $error("result produced too early");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SJF/SRTF ready queue. Requests go in over a
// valid/ready channel. A queue model predicts the result of every accepted
// request, and each result taken from the block is checked field by field
// against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    import rqss_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    // Run guard limit; this leaves a wide margin over the slowest legal run.
    localparam int CYCLE_LIMIT = 500000;
    // Worst-case request latency at full depth, plus slack.
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_PRINTS = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    req_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    rsp_t out_item;

    // Model of the ready queue: index 0 is the front.
    entry_t ready_list[$];
    // Predicted results, oldest first.
    rsp_t pending_results[$];

    int err_count = 0;
    int cycle_count = 0;
    // Per-side idle enables; cleared to get back-to-back stretches.
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;

    ready_queue_fifo_sjf_srtf_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run guard: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("[ready_queue_fifo_sjf_srtf_top] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Applies one request to the queue model and returns the result it gives.
    // Burst insert goes before the first entry with a larger burst;
    // least-remaining take keeps the earliest entry on a tie (strict compare).
    function automatic rsp_t apply_request(input req_t r);
        rsp_t res;
        entry_t e;
        int pos;
        res = '0;
        res.status = ST_OK;
        if (r.req_type == REQ_APPEND || r.req_type == REQ_INSERT)
        begin
            if (ready_list.size() >= QUEUE_DEPTH)
                res.status = ST_FULL;   // dropped, queue untouched
            else
            begin
                e.id = r.thread_id;
                e.burst = r.burst_len;
                e.remain = r.remain_len;
                pos = ready_list.size();
                if (r.req_type == REQ_INSERT)
                begin
                    for (int i = 0; i < ready_list.size(); i++)
                    begin
                        if (ready_list[i].burst > r.burst_len)
                        begin
                            pos = i;
                            break;
                        end
                    end
                end
                ready_list.insert(pos, e);
            end
        end
        else if (ready_list.size() == 0)
            res.status = ST_EMPTY;
        else
        begin
            pos = 0;
            if (r.req_type == REQ_LEAST)
            begin
                for (int i = 1; i < ready_list.size(); i++)
                    if (ready_list[i].remain < ready_list[pos].remain)
                        pos = i;
            end
            e = ready_list[pos];
            ready_list.delete(pos);
            res.out_id = e.id;
            res.out_burst = e.burst;
            res.out_remain = e.remain;
        end
        return res;
    endfunction

    function automatic req_t make_req(input req_code_t code, input logic [7:0] id,
                                      input logic [15:0] burst, input logic [15:0] remain);
        req_t r;
        r.req_type = code;
        r.thread_id = id;
        r.burst_len = burst;
        r.remain_len = remain;
        return r;
    endfunction

    // Sends one item: optional idle gap, then hold valid until accepted.
    // The prediction is made at the accepting edge.
    task automatic issue_request(input req_t r);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item <= r;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(apply_request(r));
    endtask

    // Result side: random stall before each item, then ready until taken.
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 14) : 0;
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    // Result checker: every taken item against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        rsp_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result %h", out_item));
            else
            begin
                exp = pending_results.pop_front();
                if (out_item.status !== exp.status)
                    report_mismatch($sformatf("status got %0d exp %0d",
                                              out_item.status, exp.status));
                if (out_item.out_id !== exp.out_id)
                    report_mismatch($sformatf("out_id got %h exp %h",
                                              out_item.out_id, exp.out_id));
                if (out_item.out_burst !== exp.out_burst)
                    report_mismatch($sformatf("out_burst got %h exp %h",
                                              out_item.out_burst, exp.out_burst));
                if (out_item.out_remain !== exp.out_remain)
                    report_mismatch($sformatf("out_remain got %h exp %h",
                                              out_item.out_remain, exp.out_remain));
            end
        end
    end

    // Takes on an empty queue, with all-ones fields that must be ignored.
    task automatic test_empty_queue();
        issue_request(make_req(REQ_FRONT, 8'hFF, 16'hFFFF, 16'hFFFF));
        issue_request(make_req(REQ_LEAST, 8'hFF, 16'hFFFF, 16'hFFFF));
    endtask

    // Equal-burst insert lands behind, short burst jumps to the front,
    // least-remaining tie picks the earlier entry, removal keeps the order.
    task automatic test_order_and_ties();
        issue_request(make_req(REQ_INSERT, 8'd1, 16'd100, 16'd7));
        issue_request(make_req(REQ_INSERT, 8'd2, 16'd100, 16'd7));
        issue_request(make_req(REQ_INSERT, 8'd3, 16'd0, 16'd900));
        issue_request(make_req(REQ_LEAST, 8'd0, 16'd0, 16'd0));   // id 1
        issue_request(make_req(REQ_FRONT, 8'd0, 16'd0, 16'd0));   // id 3
        issue_request(make_req(REQ_FRONT, 8'd0, 16'd0, 16'd0));   // id 2
    endtask

    // Fill to depth with field extremes, then both insert kinds are dropped.
    // The queue is left full for the random phase to drain.
    task automatic test_full_queue();
        req_code_t code;
        logic [15:0] burst;
        logic [15:0] remain;
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            code = k[0] ? REQ_INSERT : REQ_APPEND;
            case (k % 4)
                0: burst = 16'h0000;
                1: burst = 16'hFFFF;
                default: burst = 16'(k * 1000);
            endcase
            case (k % 3)
                0: remain = 16'hFFFF;
                1: remain = 16'h0000;
                default: remain = 16'(k);
            endcase
            issue_request(make_req(code, 8'(k * 17), burst, remain));
        end
        issue_request(make_req(REQ_APPEND, 8'hAA, 16'h1234, 16'h5678));
        issue_request(make_req(REQ_INSERT, 8'h55, 16'h0000, 16'h0000));
    endtask

    // Small values to force ties, extremes, or anything in range.
    function automatic logic [15:0] pick_len();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 7));
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Random traffic. The insert share swings between phases so the fill
    // level sweeps from empty to full and back; idling changes per phase.
    task automatic test_random(input int n_items);
        int insert_pct;
        req_code_t code;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 20;
                    1: insert_pct = 50;
                    default: insert_pct = 80;
                endcase
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < insert_pct)
                code = $urandom_range(0, 1) ? REQ_INSERT : REQ_APPEND;
            else
                code = $urandom_range(0, 1) ? REQ_LEAST : REQ_FRONT;
            issue_request(make_req(code, 8'($urandom_range(0, 255)),
                                   pick_len(), pick_len()));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_order_and_ties();
        test_full_queue();
        test_random(800);

        @(negedge clk);
        in_valid <= 1'b0;
        // Wait for every predicted result, then let the block settle.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("[ready_queue_fifo_sjf_srtf_top] OK");
        else
            $display("[ready_queue_fifo_sjf_srtf_top] ERROR");
        $finish;
    end

endmodule
